### rtl/spq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes of the stable priority queue core.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] prio;
  } entry_t;

endpackage
// ----------------------------------------------------------------------------
`default_nettype wire

### rtl/stable_priority_queue_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stable_priority_queue_core
// Bounded min-first priority queue, stable on equal priorities, kept sorted in
// a circular buffer held in one synchronous memory.
// ----------------------------------------------------------------------------
// The queue takes one operation at a time. A delete reads the front entry and
// hands it from the delete state to the response state; an underflow or full
// result goes straight to the response state, as does an insert into an empty
// queue. Any other insert walks the held entries from the back, one entry per
// cycle through the single read port of the entry memory, moving each entry of
// greater priority one slot back, and then writes the new entry in its slot.
// Entries are undefined after reset until written; no clearing pass is done,
// since only the data of held entries is ever used. A finished result sits in
// the output register until taken, and the next operation is accepted once the
// result is handed to that register.
module stable_priority_queue_core
  import spq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire                 operation,
  input  wire signed [31:0]   item_value,
  input  wire signed [31:0]   priority_req,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic signed [31:0]  removed_value,
  output logic [1:0]          status,
  output logic [4:0]          entry_count,
  output logic                queue_empty
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > 5) ? CW : 5;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DEL  = 5'b00010,
    S_INS  = 5'b00100,
    S_PUT  = 5'b01000,
    S_RESP = 5'b10000
  } state_t;

  function automatic logic [IW-1:0] inc_idx(input logic [IW-1:0] x);
    inc_idx = (x == IW'(CAPACITY - 1)) ? '0 : x + IW'(1);
  endfunction

  function automatic logic [IW-1:0] dec_idx(input logic [IW-1:0] x);
    dec_idx = (x == '0) ? IW'(CAPACITY - 1) : x - IW'(1);
  endfunction

  entry_t          mem [CAPACITY];
  entry_t          rd_data;
  logic [IW-1:0]   rd_addr;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  entry_t          wr_data;

  state_t          state;
  logic [IW-1:0]   head;
  logic [IW-1:0]   tail;
  logic [CW-1:0]   count;
  logic [IW-1:0]   slot;
  logic [CW-1:0]   scan_left;
  entry_t          new_entry;
  logic signed [31:0] res_value;
  status_t         res_status;

  logic            accept;
  logic            out_free;
  logic            move_back;
  logic [XW-1:0]   count_ext;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign move_back = (rd_data.prio > new_entry.prio);
  assign count_ext = XW'(count);

  always_comb begin
    rd_addr = head;
    wr_en   = 1'b0;
    wr_addr = tail;
    wr_data = new_entry;
    case (state)
      S_IDLE: begin
        rd_addr = (operation == OP_DELETE) ? head : dec_idx(tail);
        if (accept && operation == OP_INSERT && count == '0) begin
          wr_en        = 1'b1;
          wr_addr      = tail;
          wr_data.value = item_value;
          wr_data.prio  = priority_req;
        end
      end
      S_INS: begin
        rd_addr = dec_idx(dec_idx(slot));
        wr_en   = 1'b1;
        wr_addr = slot;
        wr_data = move_back ? rd_data : new_entry;
      end
      S_PUT: begin
        wr_en   = 1'b1;
        wr_addr = slot;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_RESP) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_value <= '0;
            if (operation == OP_DELETE) begin
              if (count == '0) begin
                res_status <= ST_UNDERFLOW;
                state      <= S_RESP;
              end else begin
                res_status <= ST_OK;
                state      <= S_DEL;
              end
            end else if (count == CW'(CAPACITY)) begin
              res_status <= ST_FULL;
              state      <= S_RESP;
            end else if (count == '0) begin
              res_status <= ST_OK;
              tail       <= inc_idx(tail);
              count      <= count + CW'(1);
              state      <= S_RESP;
            end else begin
              res_status      <= ST_OK;
              new_entry.value <= item_value;
              new_entry.prio  <= priority_req;
              slot            <= tail;
              scan_left       <= count;
              state           <= S_INS;
            end
          end
        end
        S_DEL: begin
          res_value <= rd_data.value;
          head      <= inc_idx(head);
          count     <= count - CW'(1);
          state     <= S_RESP;
        end
        S_INS: begin
          if (move_back) begin
            slot      <= dec_idx(slot);
            scan_left <= scan_left - CW'(1);
            if (scan_left == CW'(1)) begin
              state <= S_PUT;
            end
          end else begin
            tail  <= inc_idx(tail);
            count <= count + CW'(1);
            state <= S_RESP;
          end
        end
        S_PUT: begin
          tail  <= inc_idx(tail);
          count <= count + CW'(1);
          state <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESP && out_free) begin
      removed_value <= res_value;
      status        <= res_status;
      entry_count   <= count_ext[4:0];
      queue_empty   <= (count == '0);
    end
  end

endmodule
// ----------------------------------------------------------------------------
`default_nettype wire

### rtl/spq_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the stable priority queue core, bound to the core module.
// ----------------------------------------------------------------------------
module spq_checker
  import spq_pkg::*;
(
  input wire               clk,
  input wire               rst,
  input wire               in_valid,
  input wire               in_ready,
  input wire               out_valid,
  input wire               out_ready,
  input wire signed [31:0] removed_value,
  input wire [1:0]         status,
  input wire [4:0]         entry_count,
  input wire               queue_empty
);

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && queue_empty |-> entry_count == 5'd0)
    else $error("empty flag with nonzero count");

  a_underflow: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_UNDERFLOW |-> removed_value == 32'sd0 && queue_empty)
    else $error("underflow result not empty or carries a value");

  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> removed_value == 32'sd0 && !queue_empty)
    else $error("full result empty or carries a value");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken while an operation is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(removed_value) && $stable(status))
    else $error("stalled result changed");

endmodule

bind stable_priority_queue_core spq_checker u_spq_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .removed_value (removed_value),
  .status        (status),
  .entry_count   (entry_count),
  .queue_empty   (queue_empty)
);
// ----------------------------------------------------------------------------
`default_nettype wire

### verif/tb_stable_priority_queue_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stable_priority_queue_core
// Self-checking bench for the stable min-first priority queue. Operations are
// sent over a valid/ready channel with random gaps, results are taken with
// random stalls, and each result is compared with a sorted-list model of the
// queue that keeps equal priorities in arrival order.
// ----------------------------------------------------------------------------
module tb_stable_priority_queue_core;
  import spq_pkg::*;

  localparam int CAPACITY = 16;

  typedef struct {
    logic signed [31:0] removed;
    status_t            st;
    logic [4:0]         count;
    logic               empty;
  } queue_result_t;

  class spq_scoreboard;
    logic signed [31:0] held_values[CAPACITY];
    logic signed [31:0] held_prios[CAPACITY];
    int                 held = 0;
    queue_result_t      pending_results[$];
    int                 errors = 0;

    function void record_transfer(logic op, logic signed [31:0] v, logic signed [31:0] p);
      queue_result_t r;
      int pos;
      r.removed = '0;
      r.st = ST_OK;
      if (op == OP_INSERT) begin
        if (held >= CAPACITY) begin
          r.st = ST_FULL;
        end else begin
          pos = 0;
          while (pos < held && held_prios[pos] <= p) pos++;
          for (int i = held; i > pos; i--) begin
            held_values[i] = held_values[i-1];
            held_prios[i] = held_prios[i-1];
          end
          held_values[pos] = v;
          held_prios[pos] = p;
          held++;
        end
      end else begin
        if (held == 0) begin
          r.st = ST_UNDERFLOW;
        end else begin
          r.removed = held_values[0];
          for (int i = 1; i < held; i++) begin
            held_values[i-1] = held_values[i];
            held_prios[i-1] = held_prios[i];
          end
          held--;
        end
      end
      r.count = 5'(held);
      r.empty = (held == 0);
      pending_results.push_back(r);
    endfunction

    function void check_result(logic signed [31:0] rv, logic [1:0] st, logic [4:0] cnt,
                               logic emp);
      queue_result_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result removed_value=%0d status=%0d entry_count=%0d",
                 $time, rv, st, cnt);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (rv !== e.removed) begin
        $display("%0t: removed_value expected %0d got %0d", $time, e.removed, rv);
        errors++;
      end
      if (st !== e.st) begin
        $display("%0t: status expected %0d got %0d", $time, e.st, st);
        errors++;
      end
      if (cnt !== e.count) begin
        $display("%0t: entry_count expected %0d got %0d", $time, e.count, cnt);
        errors++;
      end
      if (emp !== e.empty) begin
        $display("%0t: queue_empty expected %0d got %0d", $time, e.empty, emp);
        errors++;
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               operation = OP_INSERT;
  logic signed [31:0] item_value = '0;
  logic signed [31:0] priority_req = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] removed_value;
  logic [1:0]         status;
  logic [4:0]         entry_count;
  logic               queue_empty;

  bit                 no_idle = 1'b0;
  spq_scoreboard      sb = new();

  stable_priority_queue_core #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .item_value   (item_value),
    .priority_req (priority_req),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .removed_value(removed_value),
    .status       (status),
    .entry_count  (entry_count),
    .queue_empty  (queue_empty)
  );

  always #10 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [31:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return -32'sd1;
      3: return 32'sd1;
      default: return 32'sd0;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(0, 7) == 0) return pick_extreme();
    return $urandom;
  endfunction

  function automatic logic signed [31:0] pick_prio(int mode);
    case (mode)
      0: return $urandom_range(0, 3);
      1: return pick_extreme();
      2: return $signed($urandom_range(0, 40)) - 32'sd20;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_op(input logic op, input logic signed [31:0] v,
                         input logic signed [31:0] p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    item_value   <= v;
    priority_req <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.record_transfer(op, v, p);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(removed_value, status, entry_count, queue_empty);
  end

  initial begin
    int run;
    int stall;
    forever begin
      run = $urandom_range(1, 12);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    int prio_mode;
    int fill_bias;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_op(OP_DELETE, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_op(OP_INSERT, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_op(OP_INSERT, 32'sh8000_0000, 32'sh8000_0000);
    send_op(OP_INSERT, 32'sd0, 32'sd0);
    send_op(OP_INSERT, -32'sd1, -32'sd1);
    send_op(OP_INSERT, 32'sd1, 32'sd0);
    send_op(OP_INSERT, 32'sd2, 32'sh7FFF_FFFF);
    send_op(OP_INSERT, 32'sd3, 32'sh8000_0000);
    for (int i = 0; i < CAPACITY - 7; i++)
      send_op(OP_INSERT, 32'sd100 + i, i % 3);
    send_op(OP_INSERT, 32'sd5, 32'sd5);
    repeat (3) send_op(OP_DELETE, $urandom, $urandom);

    for (int seg = 0; seg < 19; seg++) begin
      prio_mode = $urandom_range(0, 3);
      case ($urandom_range(0, 2))
        0: fill_bias = 25;
        1: fill_bias = 50;
        default: fill_bias = 75;
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 100; k++) begin
        if ($urandom_range(1, 100) <= fill_bias)
          send_op(OP_INSERT, pick_value(), pick_prio(prio_mode));
        else
          send_op(OP_DELETE, $urandom, $urandom);
      end
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb_stable_priority_queue_core passed");
    else
      $display("tb_stable_priority_queue_core failed");
    $finish;
  end

  initial begin
    #20000000;
    $display("tb_stable_priority_queue_core failed");
    $finish;
  end

endmodule
